[rtl/core/tkis_pkg.sv]
// Package: shared types and codes for the letter trie insert/search block.
package tkis_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LINK,
        S_TAG,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic clr_en;
        logic accept;
        logic link_step;
        logic tag_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic skip;
        logic need_tag;
        logic last;
        logic out_free;
    } t_stat;

endpackage

[rtl/core/tkis_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tkis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/tkis_ctrl.sv]
// Controller: sequences table clearing, link walk, key access and result request.
module tkis_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  tkis_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output tkis_pkg::t_cmd o_cmd
);

    tkis_pkg::t_state r_state;
    tkis_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tkis_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tkis_pkg::S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = tkis_pkg::S_IDLE;
                end
            end
            tkis_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_stat.skip ? tkis_pkg::S_DONE : tkis_pkg::S_LINK;
                end
            end
            tkis_pkg::S_LINK: begin
                o_cmd.link_step = 1'b1;
                if (i_stat.need_tag) begin
                    n_state = tkis_pkg::S_TAG;
                end else if (i_stat.last) begin
                    n_state = tkis_pkg::S_DONE;
                end else begin
                    n_state = tkis_pkg::S_IDLE;
                end
            end
            tkis_pkg::S_TAG: begin
                o_cmd.tag_step = 1'b1;
                n_state = tkis_pkg::S_DONE;
            end
            tkis_pkg::S_DONE: begin
                if (!i_stat.last) begin
                    n_state = tkis_pkg::S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = tkis_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tkis_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

[rtl/core/tkis_dp.sv]
// Datapath: walk registers, link and key tables, clear sweep and result register.
module tkis_dp #(
    parameter int NODES    = 256,
    parameter int ALPHABET = 26,
    parameter int KEY_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tkis_pkg::t_cmd  i_cmd,
    output tkis_pkg::t_stat o_stat,
    input  logic            i_command,
    input  logic [4:0]      i_letter,
    input  logic            i_last_letter,
    input  logic [15:0]     i_key_value,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [1:0]      o_status,
    output logic [15:0]     o_found_key
);

    localparam int DEPTH = NODES * ALPHABET;
    localparam int AW    = $clog2(DEPTH);
    localparam int NB    = $clog2(NODES);
    localparam int SW    = ((KEY_BITS > 16) ? KEY_BITS : 16) + 1;
    localparam int FW    = (KEY_BITS > 16) ? KEY_BITS : 16;

    // walk state
    logic [NB-1:0] r_cur;
    logic [NB-1:0] r_last_used;
    logic          r_miss;
    logic          r_full;
    logic [AW-1:0] r_clr_addr;

    // latched request
    logic          r_cmd;
    logic [4:0]    r_letter;
    logic          r_last;
    logic [15:0]   r_key;
    logic [AW-1:0] r_slot;
    logic [15:0]   r_fkey;

    // result register
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [15:0]   r_found_key;

    logic [AW-1:0]       in_slot;
    logic                letter_bad;
    logic [NB-1:0]       link_rdata;
    logic                link_zero;
    logic                link_miss;
    logic                link_full;
    logic                link_alloc;
    logic [NB-1:0]       new_node;
    logic [AW-1:0]       tag_addr;
    logic                tag_write;
    logic [SW-1:0]       key_sum;
    logic [KEY_BITS-1:0] tag_rdata;
    logic [KEY_BITS-1:0] tag_dec;
    logic                link_we;
    logic [AW-1:0]       link_waddr;
    logic [NB-1:0]       link_wdata;
    logic                tag_we;
    logic [AW-1:0]       tag_waddr;
    logic [KEY_BITS-1:0] tag_wdata;
    logic                out_free;
    logic [1:0]          res_status;

    assign letter_bad = (32'(i_letter) >= ALPHABET);
    assign in_slot    = AW'(AW'(r_cur) * AW'(ALPHABET)) + AW'(i_letter);

    assign link_zero  = (link_rdata == '0);
    assign link_miss  = link_zero && (r_cmd == tkis_pkg::CMD_SEARCH);
    assign link_full  = link_zero && !link_miss && (r_last_used >= NB'(NODES - 1));
    assign link_alloc = i_cmd.link_step && link_zero && !link_miss && !link_full;
    assign new_node   = link_zero ? (r_last_used + NB'(1)) : link_rdata;
    assign tag_addr   = AW'(AW'(new_node) * AW'(ALPHABET)) + AW'(r_letter);
    assign tag_write  = i_cmd.link_step && !link_miss && !link_full && r_last
                        && (r_cmd == tkis_pkg::CMD_INSERT);
    assign key_sum    = SW'(r_key) + SW'(1);
    assign tag_dec    = tag_rdata - KEY_BITS'(1);

    assign link_we    = i_cmd.clr_en || link_alloc;
    assign link_waddr = i_cmd.clr_en ? r_clr_addr : r_slot;
    assign link_wdata = i_cmd.clr_en ? '0 : new_node;
    assign tag_we     = i_cmd.clr_en || tag_write;
    assign tag_waddr  = i_cmd.clr_en ? r_clr_addr : tag_addr;
    assign tag_wdata  = i_cmd.clr_en ? '0 : key_sum[KEY_BITS-1:0];

    tkis_ram #(.WIDTH(NB), .DEPTH(DEPTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (in_slot),
        .o_rdata (link_rdata)
    );

    tkis_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_raddr (tag_addr),
        .o_rdata (tag_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= NB'(1);
            r_last_used <= NB'(1);
            r_miss      <= 1'b0;
            r_full      <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_en) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.accept && letter_bad && !r_miss && !r_full) begin
                r_miss <= 1'b1;
            end
            if (i_cmd.link_step) begin
                if (link_miss) begin
                    r_miss <= 1'b1;
                end else if (link_full) begin
                    r_full <= 1'b1;
                end else begin
                    r_cur <= new_node;
                end
                if (link_alloc) begin
                    r_last_used <= new_node;
                end
            end
            if (i_cmd.tag_step && (tag_rdata == '0)) begin
                r_miss <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_cur  <= NB'(1);
                r_miss <= 1'b0;
                r_full <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd    <= i_command;
            r_letter <= i_letter;
            r_last   <= i_last_letter;
            r_key    <= i_key_value;
            r_slot   <= in_slot;
        end
        if (i_cmd.tag_step) begin
            r_fkey <= 16'(FW'(tag_dec));
        end
        if (i_cmd.emit) begin
            r_status    <= res_status;
            r_found_key <= (res_status == tkis_pkg::ST_FOUND) ? r_fkey : 16'd0;
        end
    end

    always_comb begin
        priority if (r_full) begin
            res_status = tkis_pkg::ST_FULL;
        end else if (r_miss) begin
            res_status = tkis_pkg::ST_NOT_FOUND;
        end else if (r_cmd == tkis_pkg::CMD_SEARCH) begin
            res_status = tkis_pkg::ST_FOUND;
        end else begin
            res_status = tkis_pkg::ST_INSERTED;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.clr_done = (r_clr_addr == AW'(DEPTH - 1));
    assign o_stat.skip     = r_miss || r_full || letter_bad;
    assign o_stat.need_tag = r_last && (r_cmd == tkis_pkg::CMD_SEARCH) && !link_zero;
    assign o_stat.last     = r_last;
    assign o_stat.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_found_key = r_found_key;

endmodule

[rtl/core/trie_keyword_insert_search.sv]
// Top level: letter trie insert and search, one letter per request.
// A letter that is not last is handled as a link table read, then an update of the walk.
// A last letter also gets a registered result, after a key table read for a search.
// A new letter is not taken until the controller is back in idle after the previous one;
// a last letter also holds the input through its key read, if any, and while a result waits.
// Reset: the walk restarts at the root, then a clearing pass writes NODES*ALPHABET
// table entries with o_in_ready low.
module trie_keyword_insert_search #(
    parameter int NODES    = 256,
    parameter int ALPHABET = 26,
    parameter int KEY_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [4:0]  i_letter,
    input  logic        i_last_letter,
    input  logic [15:0] i_key_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_found_key
);

    tkis_pkg::t_cmd  cmd;
    tkis_pkg::t_stat stat;

    tkis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    tkis_dp #(
        .NODES    (NODES),
        .ALPHABET (ALPHABET),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_command     (i_command),
        .i_letter      (i_letter),
        .i_last_letter (i_last_letter),
        .i_key_value   (i_key_value),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_found_key   (o_found_key)
    );

endmodule

[verif/testbench.sv]
// Testbench: random and directed letter requests against a self-checking trie mirror.
`timescale 1ns / 1ps

typedef struct {
    tkis_pkg::t_status status;
    logic [15:0]       key;
} t_reply;

typedef struct packed {
    logic [2:0]      len;
    logic [5:0][4:0] ch;
} t_word;

class trie_mirror;
    localparam int NODES = 256;
    localparam int ALPHA = 26;

    logic [8:0]  links [NODES*ALPHA];
    logic [15:0] tags [NODES*ALPHA];
    int          walk_node;
    int          top_node;
    bit          missed;
    bit          filled;
    bit          full_seen;
    int          mismatches;
    t_reply      expected_replies[$];

    function new();
        foreach (links[i]) begin
            links[i] = '0;
            tags[i] = '0;
        end
        walk_node = 1;
        top_node = 1;
        missed = 0;
        filled = 0;
        full_seen = 0;
        mismatches = 0;
    endfunction

    task report(string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    function int pending();
        return expected_replies.size();
    endfunction

    function void note_letter(logic cmd, logic [4:0] ch, logic last, logic [15:0] key);
        int          idx;
        int          child;
        logic [15:0] fkey;
        t_reply      r;
        fkey = '0;
        if (!missed && !filled) begin
            if (ch >= ALPHA || walk_node >= NODES) begin
                missed = 1;
            end else begin
                idx = walk_node * ALPHA + ch;
                child = links[idx];
                if (child == 0) begin
                    if (cmd == tkis_pkg::CMD_SEARCH) begin
                        missed = 1;
                    end else if (top_node >= NODES - 1) begin
                        filled = 1;
                    end else begin
                        top_node++;
                        child = top_node;
                        links[idx] = child[8:0];
                    end
                end
                if (!missed && !filled) begin
                    walk_node = child;
                    if (last && walk_node < NODES) begin
                        idx = walk_node * ALPHA + ch;
                        if (cmd == tkis_pkg::CMD_SEARCH) begin
                            if (tags[idx] == '0) missed = 1;
                            else fkey = tags[idx] - 16'd1;
                        end else begin
                            tags[idx] = key + 16'd1;
                        end
                    end
                end
            end
        end
        if (!last) return;
        r.key = '0;
        if (filled) begin
            r.status = tkis_pkg::ST_FULL;
            full_seen = 1;
        end else if (missed) begin
            r.status = tkis_pkg::ST_NOT_FOUND;
        end else if (cmd == tkis_pkg::CMD_SEARCH) begin
            r.status = tkis_pkg::ST_FOUND;
            r.key = fkey;
        end else begin
            r.status = tkis_pkg::ST_INSERTED;
        end
        expected_replies.push_back(r);
        walk_node = 1;
        missed = 0;
        filled = 0;
    endfunction

    task check_reply(logic [1:0] status, logic [15:0] key);
        t_reply r;
        if (expected_replies.size() == 0) begin
            report($sformatf("unexpected reply status=%0d key=%0d", status, key));
            return;
        end
        r = expected_replies.pop_front();
        if (status != r.status)
            report($sformatf("status got %0d want %0d", status, r.status));
        if (key != r.key)
            report($sformatf("found_key got %0d want %0d", key, r.key));
    endtask
endclass

module testbench;
    localparam int LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_command = tkis_pkg::CMD_INSERT;
    logic [4:0]  i_letter = '0;
    logic        i_last_letter = 1'b0;
    logic [15:0] i_key_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_found_key;

    trie_mirror  trie = new();
    t_word       known[$];
    int          letters_sent = 0;
    int          cycles = 0;
    bit          calm = 0;

    trie_keyword_insert_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_letter      (i_letter),
        .i_last_letter (i_last_letter),
        .i_key_value   (i_key_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found_key   (o_found_key)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            trie.check_reply(o_status, o_found_key);
        i_out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 15);
    end

    task automatic send_letter(input logic cmd, input logic [4:0] ch, input logic last,
                               input logic [15:0] key);
        int gap;
        gap = 0;
        if (!calm) while ($urandom_range(0, 99) < 15) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_letter      <= ch;
        i_last_letter <= last;
        i_key_value   <= key;
        do @(posedge i_clk); while (!o_in_ready);
        trie.note_letter(cmd, ch, last, key);
        letters_sent++;
    endtask

    task automatic send_word(input logic cmd, input t_word w, input logic [15:0] key);
        for (int i = 0; i < w.len; i++)
            send_letter(cmd, w.ch[i], i == w.len - 1, key);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (trie.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_key();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 16'hFFFF;
        if (pick == 1) return 16'h0000;
        if (pick == 2) return 16'hFFFE;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic t_word rand_word(bit wide, int max_len);
        t_word w;
        w.len = 3'(($urandom_range(0, 3) == 0) ? $urandom_range(1, max_len)
                                                : $urandom_range(1, 3));
        for (int i = 0; i < 6; i++)
            w.ch[i] = 5'((wide || $urandom_range(0, 9) < 4) ? $urandom_range(0, 25)
                                                             : $urandom_range(0, 3));
        return w;
    endfunction

    task automatic noise_word();
        int len;
        logic [4:0] ch;
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
            ch = 5'(($urandom_range(0, 4) == 0) ? $urandom_range(26, 31)
                                                : $urandom_range(0, 3));
            send_letter($urandom_range(0, 1) ? tkis_pkg::CMD_SEARCH : tkis_pkg::CMD_INSERT,
                        ch, i == len - 1, rand_key());
        end
    endtask

    task automatic random_words(int target);
        int    pick;
        t_word w;
        while (letters_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                w = rand_word(0, 6);
                send_word(tkis_pkg::CMD_INSERT, w, rand_key());
                known.push_back(w);
                if (known.size() > 64) void'(known.pop_front());
            end else if (pick < 80 && known.size() > 0) begin
                w = known[$urandom_range(0, known.size() - 1)];
                if ($urandom_range(0, 9) == 0 && w.len > 1) w.len--;
                send_word(tkis_pkg::CMD_SEARCH, w, rand_key());
            end else if (pick < 90) begin
                send_word(tkis_pkg::CMD_SEARCH, rand_word(0, 6), rand_key());
            end else begin
                noise_word();
            end
        end
    endtask

    initial begin
        t_word w;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, missing links, empty tags, bad letters, mixed commands
        send_letter(tkis_pkg::CMD_INSERT, 5'd0, 1'b1, 16'h0000);
        send_letter(tkis_pkg::CMD_SEARCH, 5'd0, 1'b1, 16'hFFFF);
        send_letter(tkis_pkg::CMD_INSERT, 5'd25, 1'b0, 16'hFFFF);
        send_letter(tkis_pkg::CMD_INSERT, 5'd24, 1'b1, 16'hFFFF);
        send_letter(tkis_pkg::CMD_SEARCH, 5'd25, 1'b0, 16'h0000);
        send_letter(tkis_pkg::CMD_SEARCH, 5'd24, 1'b1, 16'h0000);
        send_letter(tkis_pkg::CMD_SEARCH, 5'd25, 1'b1, 16'h0000);
        send_letter(tkis_pkg::CMD_INSERT, 5'd1, 1'b0, 16'hFFFE);
        send_letter(tkis_pkg::CMD_INSERT, 5'd2, 1'b1, 16'hFFFE);
        send_letter(tkis_pkg::CMD_SEARCH, 5'd1, 1'b0, 16'h0000);
        send_letter(tkis_pkg::CMD_SEARCH, 5'd2, 1'b1, 16'h0000);
        send_letter(tkis_pkg::CMD_SEARCH, 5'd3, 1'b1, 16'h1234);
        send_letter(tkis_pkg::CMD_INSERT, 5'd31, 1'b1, 16'hAAAA);
        send_letter(tkis_pkg::CMD_SEARCH, 5'd26, 1'b1, 16'h5555);
        send_letter(tkis_pkg::CMD_INSERT, 5'd1, 1'b0, 16'h0000);
        send_letter(tkis_pkg::CMD_SEARCH, 5'd2, 1'b1, 16'h0000);
        send_letter(tkis_pkg::CMD_SEARCH, 5'd4, 1'b0, 16'h0000);
        send_letter(tkis_pkg::CMD_INSERT, 5'd5, 1'b1, 16'h0001);
        send_letter(tkis_pkg::CMD_INSERT, 5'd6, 1'b0, 16'h0000);
        send_letter(tkis_pkg::CMD_SEARCH, 5'd7, 1'b1, 16'h0000);
        send_letter(tkis_pkg::CMD_INSERT, 5'd16, 1'b0, 16'hAAAA);
        send_letter(tkis_pkg::CMD_INSERT, 5'd15, 1'b1, 16'hAAAA);
        send_letter(tkis_pkg::CMD_SEARCH, 5'd16, 1'b0, 16'h5555);
        send_letter(tkis_pkg::CMD_SEARCH, 5'd15, 1'b1, 16'h5555);

        random_words(300);
        drain();

        // long words across the whole alphabet until the node table runs out or 700 letters are sent
        while (!trie.full_seen && letters_sent < 700) begin
            w = rand_word(1, 6);
            w.len = 6;
            send_word(tkis_pkg::CMD_INSERT, w, rand_key());
            known.push_back(w);
            if (known.size() > 64) void'(known.pop_front());
        end
        drain();

        calm = 1;
        random_words(letters_sent + 150);
        calm = 0;
        random_words(775);

        drain();
        repeat (20) @(posedge i_clk);
        if (trie.mismatches == 0 && trie.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

[trie_keyword_insert_search.f]
rtl/core/tkis_pkg.sv
rtl/core/tkis_ram.sv
rtl/core/tkis_ctrl.sv
rtl/core/tkis_dp.sv
rtl/core/trie_keyword_insert_search.sv
verif/testbench.sv
